// ===== src/time_budget_task_scheduler_core_assert.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef TIME_BUDGET_TASK_SCHEDULER_CORE_ASSERT_SVH
`define TIME_BUDGET_TASK_SCHEDULER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TBS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define TBS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/tbs_pkg.sv =====
// Package with types and constants of the task scheduler.
package tbs_pkg;
  localparam int MaxTasks = 16;

  typedef enum logic [2:0] {
    KIND_TICK = 3'd0, KIND_START = 3'd1, KIND_DONE = 3'd2,
    KIND_LOAD = 3'd3, KIND_READ = 3'd4
  } kind_e;

  localparam logic [1:0] EV_DISPATCH = 2'd0;
  localparam logic [1:0] EV_FINISH   = 2'd1;
  localparam logic [1:0] EV_STATS    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_STATRD, ST_STATWR, ST_SCAN, ST_SCAN_EVAL,
    ST_FINISH, ST_DISPATCH, ST_READ, ST_OUT
  } state_e;

  typedef struct packed {
    logic       capture;    // latch input item
    logic       tick;
    logic       load;
    logic       start;      // start round bookkeeping
    logic       stat_rd;    // read stats slot of running task
    logic       done_upd;   // write back done statistics
    logic       scan_rd;    // read table entry at scan pointer
    logic       scan_next;  // advance scan pointer
    logic       dispatch;
    logic       finish;
    logic       read_rd;    // read stats slot for read item
    logic       read_out;
  } cmd_t;

  typedef struct packed {
    kind_e      kind;
    logic       running;
    logic       scan_end;
    logic       hit;
    logic       exhausted;
    logic       read_ok;
    logic       done_ok;
    logic       out_full;
  } sts_t;
endpackage

// ===== src/tbs_ctrl.sv =====
// Controller state machine of the task scheduler.
module tbs_ctrl import tbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i && !sts_i.out_full) state_d = ST_DECODE;
      ST_DECODE: begin
        case (sts_i.kind)
          KIND_START: state_d = sts_i.running ? ST_IDLE : ST_SCAN;
          KIND_DONE: state_d = sts_i.done_ok ? ST_STATRD : ST_IDLE;
          KIND_READ: state_d = sts_i.read_ok ? ST_READ : ST_IDLE;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_STATRD: state_d = ST_STATWR;
      ST_STATWR: state_d = sts_i.exhausted ? ST_FINISH : ST_SCAN;
      ST_SCAN: state_d = sts_i.scan_end ? ST_FINISH : ST_SCAN_EVAL;
      ST_SCAN_EVAL: state_d = sts_i.hit ? ST_DISPATCH : ST_SCAN;
      ST_FINISH: state_d = ST_OUT;
      ST_DISPATCH: state_d = ST_OUT;
      ST_READ: state_d = ST_OUT;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = sts_i.out_full;
        cmd_o.capture = in_valid_i && !sts_i.out_full;
      end
      ST_DECODE: begin
        cmd_o.tick = sts_i.kind == KIND_TICK;
        cmd_o.load = sts_i.kind == KIND_LOAD;
        cmd_o.start = sts_i.kind == KIND_START && !sts_i.running;
        cmd_o.stat_rd = sts_i.kind == KIND_DONE && sts_i.done_ok;
        cmd_o.read_rd = sts_i.kind == KIND_READ && sts_i.read_ok;
      end
      ST_STATWR: cmd_o.done_upd = 1'b1;
      ST_SCAN: cmd_o.scan_rd = !sts_i.scan_end;
      ST_SCAN_EVAL: cmd_o.scan_next = !sts_i.hit;
      ST_FINISH: cmd_o.finish = 1'b1;
      ST_DISPATCH: cmd_o.dispatch = 1'b1;
      ST_READ: cmd_o.read_out = 1'b1;
      default: ;
    endcase
  end

  `include "time_budget_task_scheduler_core_assert.svh"
  `TBS_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != ST_IDLE, in_stall_o)
  `TBS_ASSERT_NXT(a_eval_after_scan, clk_i, rst_ni,
    state_q == ST_SCAN && !sts_i.scan_end, state_q == ST_SCAN_EVAL)
  `TBS_ASSERT_NXT(a_out_after_hit, clk_i, rst_ni,
    state_q == ST_DISPATCH, state_q == ST_OUT)
endmodule

// ===== src/tbs_datapath.sv =====
// Datapath of the task scheduler: tables, counters and output register.
module tbs_datapath import tbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [4:0]  active_tasks_i,
  input  logic [2:0]  kind_i,
  input  logic [31:0] now_usec_i,
  input  logic [15:0] time_budget_i,
  input  logic [4:0]  task_index_i,
  input  logic [15:0] run_period_i,
  input  logic [31:0] max_time_usec_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [1:0]  event_res_o,
  output logic [4:0]  task_index_res_o,
  output logic        slip_o,
  output logic        overrun_o,
  output logic [31:0] time_sum_o,
  output logic [15:0] run_count_o,
  output logic [31:0] spare_micros_o,
  output logic [4:0]  spare_rounds_o
);
  // Item latches.
  logic [2:0]  kind_q;
  logic [31:0] now_q, allow_q;
  logic [15:0] budget_in_q, ivl_q;
  logic [4:0]  idx_q;

  // Memories, read in clocked blocks; the last-tick array is read combinationally.
  logic [15:0] ivl_mem [MaxTasks];
  logic [31:0] alw_mem [MaxTasks];
  logic [31:0] tsum_mem [MaxTasks+1];
  logic [15:0] rcnt_mem [MaxTasks+1];
  logic [MaxTasks:0] stat_vld_q;
  logic [15:0] last_tick_q [MaxTasks];

  logic [15:0] tick_q, budget_q;
  logic [31:0] prev_start_q, task_start_q, spare_sum_q, held_q;
  logic [4:0]  spare_cnt_q, pos_q;
  logic        running_q, ovr_q;
  logic [15:0] ivl_rd_q;
  logic [31:0] alw_rd_q, tsum_rd_q;
  logic [15:0] rcnt_rd_q;
  logic        rd_vld_q;

  logic [3:0] pos_idx;
  logic [4:0] limit;
  logic [31:0] taken;
  logic [15:0] dt;
  logic [16:0] ivl2;
  logic        hit;

  assign pos_idx = pos_q[3:0];
  assign limit = (active_tasks_i > 5'(MaxTasks)) ? 5'(MaxTasks) : active_tasks_i;
  assign taken = now_q - task_start_q;
  assign dt = tick_q - last_tick_q[pos_idx];
  assign ivl2 = {ivl_rd_q, 1'b0};
  assign hit = (dt >= ivl_rd_q) && (alw_rd_q <= {16'd0, budget_q});

  always_comb begin
    sts_o.kind = kind_e'(kind_q);
    sts_o.running = running_q;
    sts_o.scan_end = pos_q >= limit;
    sts_o.hit = hit;
    sts_o.exhausted = taken >= {16'd0, budget_q};
    sts_o.read_ok = idx_q <= 5'(MaxTasks);
    sts_o.done_ok = running_q;
    sts_o.out_full = out_valid_o;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i; now_q <= now_usec_i; budget_in_q <= time_budget_i;
      idx_q <= task_index_i; ivl_q <= run_period_i; allow_q <= max_time_usec_i;
    end
    if (cmd_i.load && idx_q < 5'(MaxTasks)) begin
      ivl_mem[idx_q[3:0]] <= ivl_q;
      alw_mem[idx_q[3:0]] <= allow_q;
    end
    if (cmd_i.scan_rd) begin
      ivl_rd_q <= ivl_mem[pos_idx];
      alw_rd_q <= alw_mem[pos_idx];
    end
    if (cmd_i.stat_rd) begin
      tsum_rd_q <= tsum_mem[pos_q + 5'd1];
      rcnt_rd_q <= rcnt_mem[pos_q + 5'd1];
      rd_vld_q <= stat_vld_q[pos_q + 5'd1];
    end else if (cmd_i.read_rd) begin
      tsum_rd_q <= tsum_mem[idx_q];
      rcnt_rd_q <= rcnt_mem[idx_q];
      rd_vld_q <= stat_vld_q[idx_q];
    end
    if (cmd_i.done_upd) begin
      logic [31:0] s;
      logic [15:0] c;
      s = (rd_vld_q ? tsum_rd_q : 32'd0) + taken;
      c = (rd_vld_q ? rcnt_rd_q : 16'd0) + 16'd1;
      if (c >= 16'd32) begin
        s = s >> 2; c = c >> 2;
      end
      tsum_mem[pos_q + 5'd1] <= s;
      rcnt_mem[pos_q + 5'd1] <= c;
    end else if (cmd_i.start) begin
      tsum_mem[0] <= now_q - prev_start_q;
    end else if (cmd_i.finish) begin
      rcnt_mem[0] <= (spare_cnt_q == 5'd31) ? 16'd8 : 16'(spare_cnt_q + 5'd1);
    end
  end

  // Slot 0 halves of the two tables are filled separately; track them apart.
  logic slot0_t_q, slot0_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_vld_q <= '0; slot0_t_q <= 1'b0; slot0_c_q <= 1'b0;
      tick_q <= '0; budget_q <= '0; prev_start_q <= '0; task_start_q <= '0;
      spare_sum_q <= '0; held_q <= '0; spare_cnt_q <= '0; pos_q <= '0;
      running_q <= 1'b0; ovr_q <= 1'b0; out_valid_o <= 1'b0;
      for (int i = 0; i < MaxTasks; i++) last_tick_q[i] <= '0;
    end else begin
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if (cmd_i.tick) tick_q <= tick_q + 16'd1;
      if (cmd_i.start) begin
        slot0_t_q <= 1'b1; prev_start_q <= now_q; budget_q <= budget_in_q;
        pos_q <= '0; ovr_q <= 1'b0;
      end
      if (cmd_i.done_upd) begin
        stat_vld_q[pos_q + 5'd1] <= 1'b1;
        last_tick_q[pos_idx] <= tick_q;
        ovr_q <= taken > held_q;
        running_q <= 1'b0;
        if (!sts_o.exhausted) begin
          budget_q <= budget_q - taken[15:0];
          pos_q <= pos_q + 5'd1;
        end
      end
      if (cmd_i.scan_next) pos_q <= pos_q + 5'd1;
      if (cmd_i.dispatch) begin
        held_q <= alw_rd_q; task_start_q <= now_q; running_q <= 1'b1;
        out_valid_o <= 1'b1;
        event_res_o <= EV_DISPATCH; task_index_res_o <= pos_q;
        slip_o <= {1'b0, dt} >= ivl2; overrun_o <= ovr_q;
        time_sum_o <= '0; run_count_o <= '0; spare_micros_o <= '0;
        spare_rounds_o <= '0;
      end
      if (cmd_i.finish) begin
        logic [31:0] ss;
        logic [4:0]  sc;
        ss = spare_sum_q + ((kind_q == KIND_START || !sts_o.exhausted ||
                             pos_q >= limit) && !(kind_q == KIND_DONE &&
                             sts_o.exhausted && running_q) ? {16'd0, budget_q} : 32'd0);
        sc = spare_cnt_q + 5'd1;
        if (spare_cnt_q == 5'd31) begin
          ss = ss >> 1; sc = 5'd16;
        end
        spare_sum_q <= ss; spare_cnt_q <= sc; slot0_c_q <= 1'b1;
        pos_q <= '0; running_q <= 1'b0;
        out_valid_o <= 1'b1;
        event_res_o <= EV_FINISH; task_index_res_o <= '0; slip_o <= 1'b0;
        overrun_o <= ovr_q; time_sum_o <= '0; run_count_o <= '0;
        spare_micros_o <= ss; spare_rounds_o <= sc;
      end
      if (cmd_i.read_out) begin
        out_valid_o <= 1'b1;
        event_res_o <= EV_STATS; task_index_res_o <= idx_q; slip_o <= 1'b0;
        overrun_o <= 1'b0;
        time_sum_o <= (idx_q == 5'd0) ? (slot0_t_q ? tsum_rd_q : 32'd0)
                                      : (rd_vld_q ? tsum_rd_q : 32'd0);
        run_count_o <= (idx_q == 5'd0) ? (slot0_c_q ? rcnt_rd_q : 16'd0)
                                       : (rd_vld_q ? rcnt_rd_q : 16'd0);
        spare_micros_o <= '0; spare_rounds_o <= '0;
      end
    end
  end

  `include "time_budget_task_scheduler_core_assert.svh"
  `TBS_ASSERT_IMP(a_no_dispatch_busy, clk_i, rst_ni, cmd_i.dispatch, !running_q)
  `TBS_ASSERT_IMP(a_out_hold, clk_i, rst_ni, cmd_i.capture, !out_valid_o)
  `TBS_ASSERT_NXT(a_finish_idle, clk_i, rst_ni, cmd_i.finish, !running_q && pos_q == '0)
endmodule

// ===== src/time_budget_task_scheduler_core.sv =====
// Top level of the time-budgeted cooperative task scheduler.
// Items arrive on the input channel (in_valid_i / in_stall_o); a transfer
// takes place at an edge with valid high and stall low. Results leave on
// the output channel (out_valid_o / out_stall_i) from one output register.
// A tick, load or ignored item passes through decode and gives no result.
// A read passes decode, a registered stats read and the output register.
// A start round, or a task done with budget left, walks the task table
// from the scan position over at most 16 entries; each step is the
// registered table read followed by the eligibility compare.
// Only one item is in work at a time; a new item is taken only once the
// output register is empty, so a stalled receiver holds the input back.
// The user must write the active task count (APB-style, byte address 0)
// only while the block is idle; no check enforces it. Reads return it.
// Reset clears the tick counter, the statistics (through valid bits), the
// spare accumulators and the round state. Task entries stay undefined
// until loaded.
module time_budget_task_scheduler_core import tbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] now_usec_i,
  input  logic [15:0] time_budget_i,
  input  logic [4:0]  task_index_i,
  input  logic [15:0] run_period_i,
  input  logic [31:0] max_time_usec_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_res_o,
  output logic [4:0]  task_index_res_o,
  output logic        slip_o,
  output logic        overrun_o,
  output logic [31:0] time_sum_o,
  output logic [15:0] run_count_o,
  output logic [31:0] spare_micros_o,
  output logic [4:0]  spare_rounds_o
);
  logic [4:0] active_q;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {27'd0, active_q} : 32'd0;

  // Only address 0 holds a register; other writes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) active_q <= '0;
    else if (psel && penable && pwrite && paddr == 1'b0) active_q <= pwdata[4:0];
  end

  tbs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sts_i(sts), .cmd_o(cmd)
  );

  tbs_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .active_tasks_i(active_q),
    .kind_i, .now_usec_i, .time_budget_i, .task_index_i, .run_period_i,
    .max_time_usec_i, .out_stall_i, .out_valid_o, .event_res_o,
    .task_index_res_o, .slip_o, .overrun_o, .time_sum_o, .run_count_o,
    .spare_micros_o, .spare_rounds_o
  );
endmodule
